>>> src/jan_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jan_pkg
// Shared constants and register codes of the joystick axis normalizer.
// ----------------------------------------------------------------------------
package jan_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned DB_W      = 7;
  localparam int unsigned CMD_W     = 8;
  localparam int unsigned SCALE_W   = 7;

  localparam logic [SCALE_W-1:0] SCALE         = 7'd100;
  localparam logic [DB_W-1:0]    MAG_LIMIT     = 7'd100;
  localparam logic [DB_W-1:0]    DEAD_BAND_RST = 7'd12;

  // Quotient bits: the top bit flags a quotient of 128 or more.
  localparam int unsigned QUO_BITS        = 8;
  localparam int unsigned STEPS_PER_STAGE = 2;
  localparam int unsigned DIV_STAGES      = QUO_BITS / STEPS_PER_STAGE;

  // Offset stage, scale stage, divider stages, limit stage.
  localparam int unsigned AXIS_LAT = DIV_STAGES + 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X  = 3'd0,
    REG_CENTER_Y  = 3'd1,
    REG_MIN_X     = 3'd2,
    REG_MAX_X     = 3'd3,
    REG_MIN_Y     = 3'd4,
    REG_MAX_Y     = 3'd5,
    REG_DEAD_BAND = 3'd6
  } cfg_reg_e;

endpackage

>>> src/jan_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jan_in_if
// Sample channel: one joystick sample pair and the button bit.
// ----------------------------------------------------------------------------
interface jan_in_if #(
  parameter int unsigned SAMPLE_BITS = 12
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample_x;
  logic [SAMPLE_BITS-1:0] sample_y;
  logic                   button_in;

  modport source (output valid, output sample_x, output sample_y, output button_in,
                  input ready);
  modport sink   (input valid, input sample_x, input sample_y, input button_in,
                  output ready);
endinterface

>>> src/jan_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jan_out_if
// Command channel: turn and speed commands and the button bit.
// ----------------------------------------------------------------------------
interface jan_out_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] turn_cmd;
  logic signed [7:0] speed_cmd;
  logic              button_out;

  modport source (output valid, output turn_cmd, output speed_cmd, output button_out,
                  input ready);
  modport sink   (input valid, input turn_cmd, input speed_cmd, input button_out,
                  output ready);
endinterface

>>> src/jan_axis.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jan_axis
// One axis datapath: offset and span, scale by 100, pipelined restoring
// division two quotient bits per stage, dead band and clamp.
// ----------------------------------------------------------------------------
module jan_axis import jan_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [SAMPLE_BITS-1:0]  sample_i,
  input  logic [SAMPLE_BITS-1:0]  center_i,
  input  logic [SAMPLE_BITS-1:0]  min_i,
  input  logic [SAMPLE_BITS-1:0]  max_i,
  input  logic [DB_W-1:0]         dead_band_i,
  output logic signed [CMD_W-1:0] cmd_o
);

  localparam int unsigned NUM_W = SAMPLE_BITS + SCALE_W;
  localparam int unsigned LAST  = DIV_STAGES - 1;

  // Offset stage
  logic                   ge;
  logic [SAMPLE_BITS-1:0] mag_d;
  logic [SAMPLE_BITS:0]   span_full;
  logic [SAMPLE_BITS-1:0] mag1_q, span1_q;
  logic                   neg1_q, ok1_q;

  assign ge        = sample_i >= center_i;
  assign mag_d     = ge ? (sample_i - center_i) : (center_i - sample_i);
  assign span_full = ge ? ({1'b0, max_i} - {1'b0, center_i})
                        : ({1'b0, center_i} - {1'b0, min_i});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag1_q  <= mag_d;
      span1_q <= span_full[SAMPLE_BITS-1:0];
      neg1_q  <= !ge;
      ok1_q   <= !span_full[SAMPLE_BITS] && (|span_full[SAMPLE_BITS-1:0]);
    end
  end

  // Scale stage
  logic [NUM_W-1:0]       num2_q;
  logic [SAMPLE_BITS-1:0] span2_q;
  logic                   neg2_q, ok2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num2_q  <= NUM_W'(mag1_q) * NUM_W'(SCALE);
      span2_q <= span1_q;
      neg2_q  <= neg1_q;
      ok2_q   <= ok1_q;
    end
  end

  // Divider stages
  logic [NUM_W-1:0]       rem_q  [LAST];
  logic [QUO_BITS-1:0]    quo_q  [DIV_STAGES];
  logic [SAMPLE_BITS-1:0] span_q [DIV_STAGES];
  logic                   neg_q  [DIV_STAGES];
  logic                   ok_q   [DIV_STAGES];

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    localparam int unsigned K0 = QUO_BITS - 1 - STEPS_PER_STAGE * g;
    localparam int unsigned K1 = K0 - 1;

    logic [NUM_W-1:0]       rem_in, sh0, sh1, rem_mid;
    logic [QUO_BITS-1:0]    quo_in, quo_out;
    logic [SAMPLE_BITS-1:0] span_in;
    logic                   neg_in, ok_in, t0, t1;

    if (g == 0) begin : g_first
      assign rem_in  = num2_q;
      assign quo_in  = '0;
      assign span_in = span2_q;
      assign neg_in  = neg2_q;
      assign ok_in   = ok2_q;
    end else begin : g_next
      assign rem_in  = rem_q[g-1];
      assign quo_in  = quo_q[g-1];
      assign span_in = span_q[g-1];
      assign neg_in  = neg_q[g-1];
      assign ok_in   = ok_q[g-1];
    end

    assign sh0     = NUM_W'(span_in) << K0;
    assign t0      = rem_in >= sh0;
    assign rem_mid = t0 ? (rem_in - sh0) : rem_in;
    assign sh1     = NUM_W'(span_in) << K1;
    assign t1      = rem_mid >= sh1;
    assign quo_out = quo_in | (QUO_BITS'(t0) << K0) | (QUO_BITS'(t1) << K1);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[g]  <= quo_out;
        span_q[g] <= span_in;
        neg_q[g]  <= neg_in;
        ok_q[g]   <= ok_in;
      end
    end

    if (g < LAST) begin : g_rem
      logic [NUM_W-1:0] rem_out;

      assign rem_out = t1 ? (rem_mid - sh1) : rem_mid;

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[g] <= rem_out;
        end
      end
    end
  end

  // Dead band and clamp
  logic                    sat;
  logic [DB_W-1:0]         mag_f, lim_f;
  logic                    zero_f;
  logic signed [CMD_W-1:0] cmd_d, cmd_q;

  assign sat    = quo_q[LAST][QUO_BITS-1];
  assign mag_f  = sat ? {DB_W{1'b1}} : quo_q[LAST][DB_W-1:0];
  assign zero_f = !ok_q[LAST] || (mag_f < dead_band_i);
  assign lim_f  = (mag_f > MAG_LIMIT) ? MAG_LIMIT : mag_f;

  always_comb begin
    if (zero_f) begin
      cmd_d = '0;
    end else if (neg_q[LAST]) begin
      cmd_d = -$signed({1'b0, lim_f});
    end else begin
      cmd_d = $signed({1'b0, lim_f});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cmd_q <= cmd_d;
    end
  end

  assign cmd_o = cmd_q;

endmodule

>>> src/joystick_axis_normalizer.sv
`timescale 1ns / 1ps
// An accepted sample transaction passes the axis pipeline and the output register before its command.
// Throughput: one transaction per cycle while the output is not stalled; the divider is split two quotient
// bits per stage, so every stage takes a new pair each cycle.
// A stall on the output freezes the whole pipeline; ready drops only then.
// Reset clears all valid bits and loads the calibration defaults.
// ----------------------------------------------------------------------------
// joystick_axis_normalizer
// Maps raw joystick samples to turn and speed commands in -100..100.
// ----------------------------------------------------------------------------
module joystick_axis_normalizer import jan_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [SAMPLE_BITS-1:0] cfg_data_i,
  jan_in_if.sink                 in_ch,
  jan_out_if.source              out_ch
);

  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MID = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_TOP = {SAMPLE_BITS{1'b1}};

  logic [SAMPLE_BITS-1:0] center_x_q, center_y_q, min_x_q, max_x_q, min_y_q, max_y_q;
  logic [DB_W-1:0]        dead_band_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q  <= SAMPLE_MID;
      center_y_q  <= SAMPLE_MID;
      min_x_q     <= '0;
      max_x_q     <= SAMPLE_TOP;
      min_y_q     <= '0;
      max_y_q     <= SAMPLE_TOP;
      dead_band_q <= DEAD_BAND_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_CENTER_X:  center_x_q  <= cfg_data_i;
        REG_CENTER_Y:  center_y_q  <= cfg_data_i;
        REG_MIN_X:     min_x_q     <= cfg_data_i;
        REG_MAX_X:     max_x_q     <= cfg_data_i;
        REG_MIN_Y:     min_y_q     <= cfg_data_i;
        REG_MAX_Y:     max_y_q     <= cfg_data_i;
        REG_DEAD_BAND: dead_band_q <= cfg_data_i[DB_W-1:0];
        default: ;
      endcase
    end
  end

  logic                    adv;
  logic [AXIS_LAT-1:0]     v_q, btn_q;
  logic                    out_valid_q, btn_out_q;
  logic signed [CMD_W-1:0] x_cmd, y_cmd, turn_q, speed_q;

  assign adv         = !out_valid_q || out_ch.ready;
  assign in_ch.ready = adv;

  jan_axis #(.SAMPLE_BITS(SAMPLE_BITS)) u_axis_x (
    .clk_i       (clk_i),
    .en_i        (adv),
    .sample_i    (in_ch.sample_x),
    .center_i    (center_x_q),
    .min_i       (min_x_q),
    .max_i       (max_x_q),
    .dead_band_i (dead_band_q),
    .cmd_o       (x_cmd)
  );

  jan_axis #(.SAMPLE_BITS(SAMPLE_BITS)) u_axis_y (
    .clk_i       (clk_i),
    .en_i        (adv),
    .sample_i    (in_ch.sample_y),
    .center_i    (center_y_q),
    .min_i       (min_y_q),
    .max_i       (max_y_q),
    .dead_band_i (dead_band_q),
    .cmd_o       (y_cmd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v_q         <= {v_q[AXIS_LAT-2:0], in_ch.valid};
      out_valid_q <= v_q[AXIS_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      btn_q     <= {btn_q[AXIS_LAT-2:0], in_ch.button_in};
      btn_out_q <= btn_q[AXIS_LAT-1];
      turn_q    <= x_cmd;
      speed_q   <= -y_cmd;
    end
  end

  assign out_ch.valid      = out_valid_q;
  assign out_ch.turn_cmd   = turn_q;
  assign out_ch.speed_cmd  = speed_q;
  assign out_ch.button_out = btn_out_q;

endmodule

>>> src/jan_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jan_checker
// Port-level checks of the joystick axis normalizer, bound to the top level.
// ----------------------------------------------------------------------------
module jan_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [7:0] turn_cmd,
  input logic signed [7:0] speed_cmd
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(turn_cmd) && $stable(speed_cmd))
    else $error("output transaction changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty output stage");

  a_turn_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (turn_cmd >= -8'sd100) && (turn_cmd <= 8'sd100))
    else $error("turn command out of range");

  a_speed_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (speed_cmd >= -8'sd100) && (speed_cmd <= 8'sd100))
    else $error("speed command out of range");

endmodule

bind joystick_axis_normalizer jan_checker u_jan_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .turn_cmd  (out_ch.turn_cmd),
  .speed_cmd (out_ch.speed_cmd)
);
